// File: sv/atc_pkg.sv
// Shared types, widths and constants of the altitude thrust controller.
// Used by atc_mul, atc_div and altitude_thrust_controller; no dependencies.
package atc_pkg;

  localparam int unsigned CFG_W   = 24;  // width of every configuration register
  localparam int unsigned IDX_W   = 3;   // register index width
  localparam int unsigned MUL_A_W = 34;  // signed multiplier operand A
  localparam int unsigned MUL_B_W = 25;  // signed multiplier operand B
  localparam int unsigned PROD_W  = MUL_A_W + MUL_B_W;
  localparam int unsigned WIDE_W  = 44;  // intermediate sums before saturation
  localparam int unsigned DIV_N_W = 58;  // unsigned dividend / quotient width
  localparam int unsigned DIV_D_W = 17;  // unsigned divisor width
  localparam int unsigned DIV_STEPS = DIV_N_W / 2;  // two quotient bits per cycle
  localparam int unsigned DIV_CNT_W = $clog2(DIV_STEPS);
  localparam int unsigned LIM_W   = 40;  // width of a rate limit quotient

  // 9.81 in Q16.16
  localparam logic [31:0] GRAVITY_Q16 = 32'd642908;

  localparam logic [CFG_W-1:0] ASCENT_RST  = 24'd6553600;
  localparam logic [CFG_W-1:0] DESCENT_RST = 24'd6553600;
  localparam logic [CFG_W-1:0] MASS_RST    = 24'd65536;

  typedef enum logic [IDX_W-1:0] {
    REG_POS_GAIN      = 3'd0,
    REG_INTEGRAL_GAIN = 3'd1,
    REG_VEL_GAIN      = 3'd2,
    REG_ASCENT_LIMIT  = 3'd3,
    REG_DESCENT_LIMIT = 3'd4,
    REG_VEHICLE_MASS  = 3'd5
  } reg_idx_e;

  typedef enum logic [1:0] {
    STAT_OK   = 2'd0,
    STAT_SAT  = 2'd1,
    STAT_TILT = 2'd2
  } status_e;

  typedef struct packed {
    logic busy;
    logic done;
  } div_status_t;

  typedef struct packed {
    logic        ovf;
    logic [31:0] val;
  } sat32_t;

  // Saturate a wide signed value to the 32-bit signed range.
  function automatic sat32_t sat32(input logic [WIDE_W-1:0] v);
    sat32_t r;
    r.ovf = !((v[WIDE_W-1:31] == '0) || (v[WIDE_W-1:31] == '1));
    if (r.ovf) begin
      r.val = v[WIDE_W-1] ? 32'h8000_0000 : 32'h7fff_ffff;
    end else begin
      r.val = v[31:0];
    end
    return r;
  endfunction

endpackage

// File: sv/atc_mul.sv
// Shared signed multiplier of the altitude thrust controller, product registered.
// Depends on atc_pkg for operand widths.
module atc_mul (
  input  logic                               clk_i,
  input  logic signed [atc_pkg::MUL_A_W-1:0] op_a_i,
  input  logic signed [atc_pkg::MUL_B_W-1:0] op_b_i,
  output logic signed [atc_pkg::PROD_W-1:0]  prod_o
);

  logic signed [atc_pkg::PROD_W-1:0] prod_d, prod_q;

  assign prod_d = atc_pkg::PROD_W'(op_a_i) * atc_pkg::PROD_W'(op_b_i);

  always_ff @(posedge clk_i) begin
    prod_q <= prod_d;
  end

  assign prod_o = prod_q;

endmodule

// File: sv/atc_div.sv
// Serial unsigned restoring divider, two quotient bits per cycle.
// Depends on atc_pkg for widths and the status struct.
module atc_div (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        start_i,
  input  logic [atc_pkg::DIV_N_W-1:0] dividend_i,
  input  logic [atc_pkg::DIV_D_W-1:0] divisor_i,
  output logic [atc_pkg::DIV_N_W-1:0] quotient_o,
  output atc_pkg::div_status_t        status_o
);

  logic [atc_pkg::DIV_N_W-1:0]   quo_q, quo_d;
  logic [atc_pkg::DIV_D_W-1:0]   rem_q, rem_d, dvs_q;
  logic [atc_pkg::DIV_CNT_W-1:0] cnt_q;
  logic                          busy_q, done_q;

  logic [atc_pkg::DIV_D_W:0]     r1, r2;
  logic [atc_pkg::DIV_D_W-1:0]   rem1;
  logic                          b1, b2;

  // Two dependent compare-subtract steps
  always_comb begin
    r1    = {rem_q, quo_q[atc_pkg::DIV_N_W-1]};
    b1    = (r1 >= {1'b0, dvs_q});
    rem1  = b1 ? atc_pkg::DIV_D_W'(r1 - {1'b0, dvs_q}) : r1[atc_pkg::DIV_D_W-1:0];
    r2    = {rem1, quo_q[atc_pkg::DIV_N_W-2]};
    b2    = (r2 >= {1'b0, dvs_q});
    rem_d = b2 ? atc_pkg::DIV_D_W'(r2 - {1'b0, dvs_q}) : r2[atc_pkg::DIV_D_W-1:0];
    quo_d = {quo_q[atc_pkg::DIV_N_W-3:0], b1, b2};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else if (start_i) begin
      busy_q <= 1'b1;
      done_q <= 1'b0;
      cnt_q  <= atc_pkg::DIV_CNT_W'(atc_pkg::DIV_STEPS - 1);
    end else if (busy_q) begin
      if (cnt_q == '0) begin
        busy_q <= 1'b0;
        done_q <= 1'b1;
      end else begin
        cnt_q <= cnt_q - 1'b1;
      end
    end else begin
      done_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      quo_q <= dividend_i;
      rem_q <= '0;
      dvs_q <= divisor_i;
    end else if (busy_q) begin
      quo_q <= quo_d;
      rem_q <= rem_d;
    end
  end

  assign quotient_o    = quo_q;
  assign status_o.busy = busy_q;
  assign status_o.done = done_q;

endmodule

// File: sv/altitude_thrust_controller.sv
// Top level of the altitude thrust controller: sequencer, registers, datapath.
// Depends on atc_pkg, atc_mul and atc_div.

// The tick makes five passes through the shared 34x25 multiplier, each with a
// registered product. It makes three passes through the shared divider: the two
// rate limits and the final thrust division. Each divider pass loads its operands
// and runs 29 iterations at two quotient bits per cycle before it raises done. A
// non-positive tilt cosine skips the thrust division. in_stall_o is high while a
// tick is in progress. A finished result waits in an output register, so the next
// tick is taken while the previous result is still stalled. A tick that finishes
// while that register is still full holds until it drains. The integrator saturates
// to 32 bits; status_o reports saturation or a non-positive tilt cosine (then
// thrust_o is zero). Write configuration through cfg_we_i only while no tick is in
// flight; writes to unused indexes are ignored.
module altitude_thrust_controller (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_we_i,
  input  logic [atc_pkg::IDX_W-1:0]     cfg_index_i,
  input  logic [atc_pkg::CFG_W-1:0]     cfg_wdata_i,
  input  logic                          in_valid_i,
  output logic                          in_stall_o,
  input  logic signed [31:0]            target_height_i,
  input  logic signed [31:0]            target_climb_i,
  input  logic signed [31:0]            measured_height_i,
  input  logic signed [31:0]            measured_climb_i,
  input  logic signed [31:0]            feed_accel_i,
  input  logic signed [15:0]            tilt_cosine_i,
  input  logic [15:0]                   time_step_i,
  output logic                          out_valid_o,
  input  logic                          out_stall_i,
  output logic signed [31:0]            thrust_o,
  output logic [1:0]                    status_o
);

  localparam int unsigned WW = atc_pkg::WIDE_W;
  localparam int unsigned PW = atc_pkg::PROD_W;

  typedef enum logic [15:0] {
    ST_IDLE  = 16'b0000_0000_0000_0001,
    ST_ERRDT = 16'b0000_0000_0000_0010,
    ST_SUM   = 16'b0000_0000_0000_0100,
    ST_POS   = 16'b0000_0000_0000_1000,
    ST_INT   = 16'b0000_0000_0001_0000,
    ST_VEL   = 16'b0000_0000_0010_0000,
    ST_ACC   = 16'b0000_0000_0100_0000,
    ST_DLO   = 16'b0000_0000_1000_0000,
    ST_DHI   = 16'b0000_0001_0000_0000,
    ST_CLAMP = 16'b0000_0010_0000_0000,
    ST_SAT   = 16'b0000_0100_0000_0000,
    ST_MASS  = 16'b0000_1000_0000_0000,
    ST_TDIV  = 16'b0001_0000_0000_0000,
    ST_TWAIT = 16'b0010_0000_0000_0000,
    ST_OUT   = 16'b0100_0000_0000_0000
  } state_e;

  state_e state_q, state_d;

  // configuration registers
  logic [atc_pkg::CFG_W-1:0] pos_gain_q, int_gain_q, vel_gain_q;
  logic [atc_pkg::CFG_W-1:0] ascent_q, descent_q, mass_q;

  // latched transaction payload
  logic signed [32:0] err_q;
  logic signed [31:0] tc_q, mc_q, ff_q;
  logic [15:0]        dt_q;
  logic [14:0]        tilt_q;
  logic               tilt_bad_q;

  // working registers
  logic signed [31:0] hes_q, hes_d;
  logic [WW-1:0]      wide_q, wide_d;
  logic [31:0]        climb_q, climb_d, acc_q, acc_d;
  logic [atc_pkg::LIM_W-1:0] lim_q, lim_d;
  logic               sat_q, sat_d, neg_q, neg_d;

  // output register
  logic               out_valid_q, out_valid_d;
  logic [31:0]        thrust_q, thrust_d;
  logic [1:0]         status_q, status_d;

  // shared units
  logic signed [atc_pkg::MUL_A_W-1:0] mul_a;
  logic signed [atc_pkg::MUL_B_W-1:0] mul_b;
  logic signed [PW-1:0]               prod;
  logic                               div_start;
  logic [atc_pkg::DIV_N_W-1:0]        div_n, quot;
  logic [atc_pkg::DIV_D_W-1:0]        div_d;
  atc_pkg::div_status_t               div_st;

  logic               in_accept, out_free;
  logic [WW-1:0]      prod_sh, lo_w, hi_w;
  logic [32:0]        vdiff;
  logic [PW-1:0]      prod_abs;
  atc_pkg::sat32_t    sres;
  logic               t_ovf;
  logic [31:0]        t_val;

  atc_mul u_mul (
    .clk_i  (clk_i),
    .op_a_i (mul_a),
    .op_b_i (mul_b),
    .prod_o (prod)
  );

  atc_div u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i (div_n),
    .divisor_i  (div_d),
    .quotient_o (quot),
    .status_o   (div_st)
  );

  assign in_stall_o = (state_q != ST_IDLE);
  assign in_accept  = in_valid_i && !in_stall_o;
  assign out_free   = !out_valid_q || !out_stall_i;

  // product shifted right by 16 with floor rounding, sign extended
  assign prod_sh  = WW'($signed(prod[PW-1:16]));
  assign vdiff    = {climb_q[31], climb_q} - {mc_q[31], mc_q};
  assign prod_abs = prod[PW-1] ? PW'(-prod) : PW'(prod);
  assign lo_w     = WW'(-$signed({1'b0, lim_q}));
  assign hi_w     = WW'({1'b0, quot[atc_pkg::LIM_W-1:0]});

  // configuration port
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_gain_q <= '0;
      int_gain_q <= '0;
      vel_gain_q <= '0;
      ascent_q   <= atc_pkg::ASCENT_RST;
      descent_q  <= atc_pkg::DESCENT_RST;
      mass_q     <= atc_pkg::MASS_RST;
    end else if (cfg_we_i) begin
      case (atc_pkg::reg_idx_e'(cfg_index_i))
        atc_pkg::REG_POS_GAIN:      pos_gain_q <= cfg_wdata_i;
        atc_pkg::REG_INTEGRAL_GAIN: int_gain_q <= cfg_wdata_i;
        atc_pkg::REG_VEL_GAIN:      vel_gain_q <= cfg_wdata_i;
        atc_pkg::REG_ASCENT_LIMIT:  ascent_q   <= cfg_wdata_i;
        atc_pkg::REG_DESCENT_LIMIT: descent_q  <= cfg_wdata_i;
        atc_pkg::REG_VEHICLE_MASS:  mass_q     <= cfg_wdata_i;
        default: ;
      endcase
    end
  end

  // multiplier and divider operand selection
  always_comb begin
    mul_a     = '0;
    mul_b     = '0;
    div_start = 1'b0;
    div_n     = {18'd0, ascent_q, 16'd0};
    div_d     = {1'b0, dt_q};
    case (state_q)
      ST_ERRDT: begin
        mul_a = atc_pkg::MUL_A_W'(err_q);
        mul_b = {9'd0, dt_q};
      end
      ST_SUM: begin
        mul_a = atc_pkg::MUL_A_W'(err_q);
        mul_b = {1'b0, pos_gain_q};
      end
      ST_POS: begin
        mul_a = atc_pkg::MUL_A_W'(hes_q);
        mul_b = {1'b0, int_gain_q};
      end
      ST_VEL: begin
        mul_a = atc_pkg::MUL_A_W'($signed(vdiff));
        mul_b = {1'b0, vel_gain_q};
      end
      ST_MASS: begin
        mul_a = {2'b00, atc_pkg::GRAVITY_Q16} - {{2{acc_q[31]}}, acc_q};
        mul_b = {1'b0, mass_q};
      end
      ST_ACC: begin
        div_start = 1'b1;
      end
      ST_DLO: begin
        div_start = div_st.done;
        div_n     = {18'd0, descent_q, 16'd0};
      end
      ST_TDIV: begin
        div_start = !tilt_bad_q;
        div_n     = prod_abs[atc_pkg::DIV_N_W-1:0];
        div_d     = {tilt_q, 2'b00};
      end
      default: ;
    endcase
  end

  // signed thrust from the quotient magnitude, saturated
  always_comb begin
    if (neg_q) begin
      t_ovf = (quot[atc_pkg::DIV_N_W-1:32] != '0) || (quot[31] && (quot[30:0] != '0));
      t_val = t_ovf ? 32'h8000_0000 : 32'(-quot[31:0]);
    end else begin
      t_ovf = (quot[atc_pkg::DIV_N_W-1:31] != '0);
      t_val = t_ovf ? 32'h7fff_ffff : quot[31:0];
    end
  end

  // sequencer and datapath
  always_comb begin
    state_d     = state_q;
    hes_d       = hes_q;
    wide_d      = wide_q;
    climb_d     = climb_q;
    acc_d       = acc_q;
    lim_d       = lim_q;
    sat_d       = sat_q;
    neg_d       = neg_q;
    out_valid_d = out_valid_q && out_stall_i;
    thrust_d    = thrust_q;
    status_d    = status_q;
    sres        = atc_pkg::sat32(wide_q);
    case (state_q)
      ST_IDLE: begin
        if (in_accept) begin
          sat_d   = 1'b0;
          state_d = ST_ERRDT;
        end
      end
      ST_ERRDT: state_d = ST_SUM;
      ST_SUM: begin
        sres  = atc_pkg::sat32(WW'(hes_q) + prod_sh);
        hes_d = sres.val;
        sat_d = sat_q | sres.ovf;
        state_d = ST_POS;
      end
      ST_POS: begin
        wide_d  = WW'(tc_q) + prod_sh;
        state_d = ST_INT;
      end
      ST_INT: begin
        sres    = atc_pkg::sat32(wide_q + prod_sh);
        climb_d = sres.val;
        sat_d   = sat_q | sres.ovf;
        state_d = ST_VEL;
      end
      ST_VEL: state_d = ST_ACC;
      ST_ACC: begin
        wide_d  = WW'(ff_q) + prod_sh;
        state_d = ST_DLO;
      end
      ST_DLO: begin
        if (div_st.done) begin
          lim_d   = quot[atc_pkg::LIM_W-1:0];
          state_d = ST_DHI;
        end
      end
      ST_DHI: begin
        if (div_st.done) begin
          state_d = ST_CLAMP;
        end
      end
      ST_CLAMP: begin
        // zero step leaves the acceleration unbounded
        if (dt_q != '0) begin
          if ($signed(wide_q) < $signed(lo_w)) begin
            wide_d = lo_w;
          end else if ($signed(wide_q) > $signed(hi_w)) begin
            wide_d = hi_w;
          end
        end
        state_d = ST_SAT;
      end
      ST_SAT: begin
        acc_d   = sres.val;
        sat_d   = sat_q | sres.ovf;
        state_d = ST_MASS;
      end
      ST_MASS: state_d = ST_TDIV;
      ST_TDIV: begin
        neg_d   = prod[PW-1];
        state_d = tilt_bad_q ? ST_OUT : ST_TWAIT;
      end
      ST_TWAIT: begin
        if (div_st.done) begin
          state_d = ST_OUT;
        end
      end
      ST_OUT: begin
        // hold until the output register is free
        if (out_free) begin
          out_valid_d = 1'b1;
          if (tilt_bad_q) begin
            thrust_d = '0;
            status_d = atc_pkg::STAT_TILT;
          end else begin
            thrust_d = t_val;
            status_d = (sat_q || t_ovf) ? atc_pkg::STAT_SAT : atc_pkg::STAT_OK;
          end
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      hes_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      hes_q       <= hes_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_accept) begin
      err_q      <= {target_height_i[31], target_height_i}
                    - {measured_height_i[31], measured_height_i};
      tc_q       <= target_climb_i;
      mc_q       <= measured_climb_i;
      ff_q       <= feed_accel_i;
      dt_q       <= time_step_i;
      tilt_q     <= tilt_cosine_i[14:0];
      tilt_bad_q <= tilt_cosine_i[15] || (tilt_cosine_i == '0);
    end
    wide_q   <= wide_d;
    climb_q  <= climb_d;
    acc_q    <= acc_d;
    lim_q    <= lim_d;
    sat_q    <= sat_d;
    neg_q    <= neg_d;
    thrust_q <= thrust_d;
    status_q <= status_d;
  end

  assign out_valid_o = out_valid_q;
  assign thrust_o    = thrust_q;
  assign status_o    = status_q;

endmodule

// File: tb/sv/altitude_thrust_controller_tb.sv
`timescale 1ns / 100ps
// Self-checking testbench of altitude_thrust_controller: a scoreboard class predicts
// thrust and status per control tick. Plain tasks drive the tick and config ports.
// Depends on atc_pkg and the altitude_thrust_controller RTL.
module altitude_thrust_controller_tb;
  import atc_pkg::*;

  localparam longint Q16_MAX = 64'sd2147483647;
  localparam longint Q16_MIN = -64'sd2147483648;
  localparam int     Q_ONE   = 65536;
  localparam int     TILT_ONE = 16384;
  localparam int     HEIGHT_SPAN = 1000 * Q_ONE;
  localparam int     ERR_SPAN    = 5 * Q_ONE;
  localparam int     CLIMB_SPAN  = 10 * Q_ONE;
  localparam int     ACCEL_SPAN  = 5 * Q_ONE;
  localparam int     RANDOM_PER_PHASE = 90;
  localparam int     NUM_PHASES = 6;
  // indexes past the register file, writes there must be dropped
  localparam logic [IDX_W-1:0] REG_UNUSED_LO = 3'd6;
  localparam logic [IDX_W-1:0] REG_UNUSED_HI = 3'd7;

  typedef struct {
    int          target_height;
    int          target_climb;
    int          measured_height;
    int          measured_climb;
    int          feed_accel;
    shortint     tilt_cosine;
    logic [15:0] time_step;
  } tick_t;

  typedef struct {
    int      thrust;
    status_e status;
  } thrust_cmd_t;

  typedef struct {
    logic [CFG_W-1:0] pos_gain;
    logic [CFG_W-1:0] integral_gain;
    logic [CFG_W-1:0] vel_gain;
    logic [CFG_W-1:0] ascent_limit;
    logic [CFG_W-1:0] descent_limit;
    logic [CFG_W-1:0] vehicle_mass;
  } ctrl_cfg_t;

  class thrust_scoreboard;
    ctrl_cfg_t   regs;
    longint      height_err_sum;
    thrust_cmd_t expected_thrust_q[$];
    int unsigned errors;

    function new();
      regs.pos_gain      = '0;
      regs.integral_gain = '0;
      regs.vel_gain      = '0;
      regs.ascent_limit  = ASCENT_RST;
      regs.descent_limit = DESCENT_RST;
      regs.vehicle_mass  = MASS_RST;
      height_err_sum = 0;
      errors = 0;
    endfunction

    function void write_reg(input logic [IDX_W-1:0] idx, input logic [CFG_W-1:0] data);
      case (idx)
        REG_POS_GAIN:      regs.pos_gain      = data;
        REG_INTEGRAL_GAIN: regs.integral_gain = data;
        REG_VEL_GAIN:      regs.vel_gain      = data;
        REG_ASCENT_LIMIT:  regs.ascent_limit  = data;
        REG_DESCENT_LIMIT: regs.descent_limit = data;
        REG_VEHICLE_MASS:  regs.vehicle_mass  = data;
        default: ;
      endcase
    endfunction

    function longint clamp32(input longint v, inout bit flag);
      if (v > Q16_MAX) begin
        flag = 1'b1;
        return Q16_MAX;
      end
      if (v < Q16_MIN) begin
        flag = 1'b1;
        return Q16_MIN;
      end
      return v;
    endfunction

    // Predict one tick; arithmetic shifts of longint round toward minus infinity.
    function void note_tick(input tick_t t);
      longint      err, sum, climb, accel, lo, hi, num, dt;
      bit          sat;
      thrust_cmd_t exp_cmd;
      sat   = 1'b0;
      dt    = longint'(t.time_step);
      err   = longint'(t.target_height) - longint'(t.measured_height);
      sum   = clamp32(height_err_sum + ((err * dt) >>> 16), sat);
      height_err_sum = sum;
      climb = longint'(t.target_climb) + ((longint'(regs.pos_gain) * err) >>> 16)
              + ((longint'(regs.integral_gain) * sum) >>> 16);
      climb = clamp32(climb, sat);
      accel = longint'(t.feed_accel)
              + ((longint'(regs.vel_gain) * (climb - longint'(t.measured_climb))) >>> 16);
      if (dt != 0) begin
        lo = -((longint'(regs.ascent_limit) << 16) / dt);
        hi = (longint'(regs.descent_limit) << 16) / dt;
        if (accel < lo) accel = lo;
        if (accel > hi) accel = hi;
      end
      accel = clamp32(accel, sat);
      if (t.tilt_cosine <= 0) begin
        exp_cmd.thrust = 0;
        exp_cmd.status = STAT_TILT;
      end else begin
        num = longint'(regs.vehicle_mass) * (longint'(GRAVITY_Q16) - accel);
        exp_cmd.thrust = int'(clamp32(num / (longint'(t.tilt_cosine) * 4), sat));
        exp_cmd.status = sat ? STAT_SAT : STAT_OK;
      end
      expected_thrust_q.push_back(exp_cmd);
    endfunction

    function void check_result(input logic [31:0] thrust, input logic [1:0] status);
      thrust_cmd_t exp_cmd;
      if (expected_thrust_q.size() == 0) begin
        if (errors < 10) $display("%0t: result with no tick pending: thrust %0d status %0d",
                                  $time, $signed(thrust), status);
        errors++;
        return;
      end
      exp_cmd = expected_thrust_q.pop_front();
      if (thrust !== exp_cmd.thrust || status !== exp_cmd.status) begin
        if (errors < 10)
          $display("%0t: mismatch: thrust exp %0d got %0d, status exp %0d got %0d", $time,
                   exp_cmd.thrust, $signed(thrust), exp_cmd.status, status);
        errors++;
      end
    endfunction

    function int unsigned pending();
      return expected_thrust_q.size();
    endfunction
  endclass

  logic                 clk_i;
  logic                 rst_ni;
  logic                 cfg_we_i;
  logic [IDX_W-1:0]     cfg_index_i;
  logic [CFG_W-1:0]     cfg_wdata_i;
  logic                 in_valid_i;
  logic                 in_stall_o;
  logic signed [31:0]   target_height_i;
  logic signed [31:0]   target_climb_i;
  logic signed [31:0]   measured_height_i;
  logic signed [31:0]   measured_climb_i;
  logic signed [31:0]   feed_accel_i;
  logic signed [15:0]   tilt_cosine_i;
  logic [15:0]          time_step_i;
  logic                 out_valid_o;
  logic                 out_stall_i;
  logic signed [31:0]   thrust_o;
  logic [1:0]           status_o;

  thrust_scoreboard sb;
  int tx_idle_pct;
  int rx_idle_pct;

  altitude_thrust_controller dut (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .cfg_we_i          (cfg_we_i),
    .cfg_index_i       (cfg_index_i),
    .cfg_wdata_i       (cfg_wdata_i),
    .in_valid_i        (in_valid_i),
    .in_stall_o        (in_stall_o),
    .target_height_i   (target_height_i),
    .target_climb_i    (target_climb_i),
    .measured_height_i (measured_height_i),
    .measured_climb_i  (measured_climb_i),
    .feed_accel_i      (feed_accel_i),
    .tilt_cosine_i     (tilt_cosine_i),
    .time_step_i       (time_step_i),
    .out_valid_o       (out_valid_o),
    .out_stall_i       (out_stall_i),
    .thrust_o          (thrust_o),
    .status_o          (status_o)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  initial begin
    #5_000_000;
    $display("DONE: errors detected");
    $finish;
  end

  function automatic tick_t mk_tick(input int th, input int tc, input int mh, input int mc,
                                    input int ff, input int tilt, input int dt);
    tick_t t;
    t.target_height   = th;
    t.target_climb    = tc;
    t.measured_height = mh;
    t.measured_climb  = mc;
    t.feed_accel      = ff;
    t.tilt_cosine     = shortint'(tilt);
    t.time_step       = dt[15:0];
    return t;
  endfunction

  // Mostly plausible flight ticks; wild ones cover the full ranges of the 32-bit fields.
  function automatic tick_t rand_tick(input bit wild);
    tick_t t;
    if (wild) begin
      t.target_height   = $urandom;
      t.target_climb    = $urandom;
      t.measured_height = $urandom;
      t.measured_climb  = $urandom;
      t.feed_accel      = $urandom;
      t.tilt_cosine     = shortint'(int'($urandom_range(0, 2 * TILT_ONE)) - TILT_ONE);
      t.time_step       = 16'($urandom_range(1, 65535));
    end else begin
      t.measured_height = int'($urandom_range(0, 2 * HEIGHT_SPAN)) - HEIGHT_SPAN;
      t.target_height   = t.measured_height + int'($urandom_range(0, 2 * ERR_SPAN)) - ERR_SPAN;
      t.target_climb    = int'($urandom_range(0, 2 * CLIMB_SPAN)) - CLIMB_SPAN;
      t.measured_climb  = int'($urandom_range(0, 2 * CLIMB_SPAN)) - CLIMB_SPAN;
      t.feed_accel      = int'($urandom_range(0, 2 * ACCEL_SPAN)) - ACCEL_SPAN;
      if ($urandom_range(99) < 90)
        t.tilt_cosine = shortint'($urandom_range(TILT_ONE / 2, TILT_ONE));
      else
        t.tilt_cosine = shortint'(int'($urandom_range(0, TILT_ONE)) - TILT_ONE);
      t.time_step = 16'($urandom_range(16, 4096));
    end
    return t;
  endfunction

  function automatic ctrl_cfg_t rand_cfg(input bit full);
    ctrl_cfg_t c;
    if (full) begin
      c.pos_gain      = CFG_W'($urandom_range(0, 16777215));
      c.integral_gain = CFG_W'($urandom_range(0, 16777215));
      c.vel_gain      = CFG_W'($urandom_range(0, 16777215));
      c.ascent_limit  = CFG_W'($urandom_range(0, 16777215));
      c.descent_limit = CFG_W'($urandom_range(0, 16777215));
      c.vehicle_mass  = CFG_W'($urandom_range(0, 16777215));
    end else begin
      c.pos_gain      = CFG_W'($urandom_range(0, 4 * Q_ONE));
      c.integral_gain = CFG_W'($urandom_range(0, Q_ONE));
      c.vel_gain      = CFG_W'($urandom_range(0, 4 * Q_ONE));
      c.ascent_limit  = CFG_W'($urandom_range(Q_ONE, 20 * Q_ONE));
      c.descent_limit = CFG_W'($urandom_range(Q_ONE, 20 * Q_ONE));
      c.vehicle_mass  = CFG_W'($urandom_range(Q_ONE / 2, 5 * Q_ONE));
    end
    return c;
  endfunction

  task automatic write_reg(input logic [IDX_W-1:0] idx, input logic [CFG_W-1:0] data);
    cfg_we_i    <= 1'b1;
    cfg_index_i <= idx;
    cfg_wdata_i <= data;
    @(posedge clk_i);
    sb.write_reg(idx, data);
  endtask

  task automatic load_config(input ctrl_cfg_t c);
    write_reg(REG_POS_GAIN, c.pos_gain);
    write_reg(REG_UNUSED_LO, CFG_W'($urandom));
    write_reg(REG_INTEGRAL_GAIN, c.integral_gain);
    write_reg(REG_VEL_GAIN, c.vel_gain);
    write_reg(REG_ASCENT_LIMIT, c.ascent_limit);
    write_reg(REG_DESCENT_LIMIT, c.descent_limit);
    write_reg(REG_VEHICLE_MASS, c.vehicle_mass);
    write_reg(REG_UNUSED_HI, CFG_W'($urandom));
    cfg_we_i <= 1'b0;
  endtask

  // Hold off new ticks until every predicted result has come back.
  task automatic drain();
    in_valid_i <= 1'b0;
    while (sb.pending() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  task automatic send_tick(input tick_t t);
    if ($urandom_range(99) < tx_idle_pct) begin
      in_valid_i <= 1'b0;
      do @(posedge clk_i); while ($urandom_range(99) < tx_idle_pct);
    end
    target_height_i   <= t.target_height;
    target_climb_i    <= t.target_climb;
    measured_height_i <= t.measured_height;
    measured_climb_i  <= t.measured_climb;
    feed_accel_i      <= t.feed_accel;
    tilt_cosine_i     <= t.tilt_cosine;
    time_step_i       <= t.time_step;
    in_valid_i        <= 1'b1;
    do @(posedge clk_i); while (in_stall_o);
    sb.note_tick(t);
  endtask

  initial begin : result_sink
    out_stall_i <= 1'b0;
    forever begin
      @(posedge clk_i);
      if (rst_ni && out_valid_o && !out_stall_i) sb.check_result(thrust_o, status_o);
      out_stall_i <= ($urandom_range(99) < rx_idle_pct);
    end
  end

  initial begin : stimulus
    ctrl_cfg_t   c;
    tick_t       directed_q[$];
    int          imax;
    int          imin;
    int unsigned total_errors;
    sb = new();
    imax = 32'sh7fff_ffff;
    imin = 32'sh8000_0000;
    tx_idle_pct = 0;
    rx_idle_pct = 0;
    rst_ni            <= 1'b0;
    cfg_we_i          <= 1'b0;
    cfg_index_i       <= '0;
    cfg_wdata_i       <= '0;
    in_valid_i        <= 1'b0;
    target_height_i   <= '0;
    target_climb_i    <= '0;
    measured_height_i <= '0;
    measured_climb_i  <= '0;
    feed_accel_i      <= '0;
    tilt_cosine_i     <= '0;
    time_step_i       <= '0;
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // hover, tilt edge cases, saturation of every stage, zero step
    directed_q.push_back(mk_tick(0, 0, 0, 0, 0, TILT_ONE, 1000));
    directed_q.push_back(mk_tick(Q_ONE, 0, 0, 0, 0, 0, 1000));
    directed_q.push_back(mk_tick(0, Q_ONE, 0, 0, 0, -TILT_ONE, 1000));
    directed_q.push_back(mk_tick(0, 0, Q_ONE, 0, 0, -1, 1000));
    directed_q.push_back(mk_tick(0, 0, 0, 0, 0, 1, 500));
    directed_q.push_back(mk_tick(imax, 0, imin, 0, 0, TILT_ONE, 65535));
    directed_q.push_back(mk_tick(imax, 0, imin, 0, 0, TILT_ONE, 65535));
    directed_q.push_back(mk_tick(imin, 0, imax, 0, 0, TILT_ONE, 65535));
    directed_q.push_back(mk_tick(imin, 0, imax, 0, 0, TILT_ONE, 65535));
    directed_q.push_back(mk_tick(imin, 0, imax, 0, 0, TILT_ONE, 65535));
    directed_q.push_back(mk_tick(Q_ONE, 0, 0, 0, 0, TILT_ONE, 1));
    directed_q.push_back(mk_tick(0, 0, 0, 0, imax, TILT_ONE, 0));
    directed_q.push_back(mk_tick(0, 0, 0, 0, imin, TILT_ONE, 0));
    directed_q.push_back(mk_tick(0, 0, 0, 0, imax, TILT_ONE, 1000));
    directed_q.push_back(mk_tick(0, 0, 0, 0, imin, TILT_ONE, 1000));
    directed_q.push_back(mk_tick(0, imax, 0, imin, 0, TILT_ONE, 2000));
    directed_q.push_back(mk_tick(0, imin, 0, imax, 0, 1, 2000));
    directed_q.push_back(mk_tick(imax, imax, imax, imax, imax, TILT_ONE, 65535));
    directed_q.push_back(mk_tick(imin, imin, imin, imin, imin, -TILT_ONE, 1));
    directed_q.push_back(mk_tick(-Q_ONE, -Q_ONE, 0, -1, -1, TILT_ONE / 2, 65535));

    for (int ph = 0; ph < NUM_PHASES; ph++) begin
      case (ph)
        0: begin
          c.pos_gain      = CFG_W'(Q_ONE);
          c.integral_gain = CFG_W'(Q_ONE / 2);
          c.vel_gain      = CFG_W'(2 * Q_ONE);
          c.ascent_limit  = CFG_W'(5 * Q_ONE);
          c.descent_limit = CFG_W'(3 * Q_ONE);
          c.vehicle_mass  = CFG_W'(3 * Q_ONE / 2);
        end
        2: begin
          c.pos_gain      = '1;
          c.integral_gain = '1;
          c.vel_gain      = '1;
          c.ascent_limit  = '1;
          c.descent_limit = '1;
          c.vehicle_mass  = '1;
        end
        3: begin
          c.pos_gain      = '0;
          c.integral_gain = '0;
          c.vel_gain      = '0;
          c.ascent_limit  = '0;
          c.descent_limit = '0;
          c.vehicle_mass  = '0;
        end
        4: begin
          c.pos_gain      = '0;
          c.integral_gain = '0;
          c.vel_gain      = '0;
          c.ascent_limit  = ASCENT_RST;
          c.descent_limit = DESCENT_RST;
          c.vehicle_mass  = MASS_RST;
        end
        5:       c = rand_cfg(1'b1);
        default: c = rand_cfg(1'b0);
      endcase
      drain();
      // sender dense / receiver busy, then swapped, then free running
      tx_idle_pct = (ph < 2) ? 12 : (ph < 4) ? 78 : 0;
      rx_idle_pct = (ph < 2) ? 78 : (ph < 4) ? 12 : 0;
      load_config(c);
      if (ph == 0) begin
        foreach (directed_q[i]) send_tick(directed_q[i]);
      end
      for (int n = 0; n < RANDOM_PER_PHASE; n++) begin
        send_tick(rand_tick($urandom_range(99) < 20));
        if (ph == 1 && n == RANDOM_PER_PHASE / 2) drain();
      end
    end

    drain();
    repeat (120) @(posedge clk_i);
    total_errors = sb.errors + sb.pending();
    if (total_errors == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule

// File: filelist.f
sv/atc_pkg.sv
sv/atc_mul.sv
sv/atc_div.sv
sv/altitude_thrust_controller.sv
tb/sv/altitude_thrust_controller_tb.sv
